@@ sv/fipwf_pkg.sv @@
// shared types and constants for the worst-fit free slot pool
package fipwf_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] word_t;

    typedef enum logic [1:0] {
        CMD_FRESH    = 2'd0,
        CMD_RELEASED = 2'd1,
        CMD_REQUEST  = 2'd2,
        CMD_UNUSED   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_GRANTED  = 2'd1,
        STAT_NONE     = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD      = 2'd0,
        OP_INSERT    = 2'd1,
        OP_POP_FRONT = 2'd2
    } cell_op_t;

    typedef struct packed {
        word_t idx;
        word_t size;
    } entry_t;

    typedef struct packed {
        logic     capture;
        word_t    key;
        cell_op_t op;
        logic     front;
        logic     back;
        entry_t   new_entry;
    } cell_ctrl_t;

    typedef struct packed {
        cmd_t  cmd;
        word_t index_order;
        word_t block_size;
        word_t req_size;
    } in_t;

    typedef struct packed {
        status_t status;
        word_t   granted_index;
        word_t   granted_size;
        cnt_t    entries_held;
        cnt_t    fresh_held;
    } out_t;

endpackage

@@ sv/free_index_pool_worst_fit_core.sv @@
// worst-fit free slot pool built as a shifting sorted row of cells
//
//  channel | ports                   | payload | direction
//  --------+-------------------------+---------+----------
//  input   | s_valid s_ready s_data  | in_t    | in
//  result  | m_valid m_ready m_data  | out_t   | out
//
// per item, the transfer cycle latches every cell's compare against
// the key plus the largest entry, then the apply cycle shifts the row and loads the result
// the apply cycle waits while the previous result is still held on m_data
// aresetn empties the pool at once; cell contents keep no reset
module free_index_pool_worst_fit_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fipwf_pkg::in_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fipwf_pkg::out_t   m_data
);

    localparam int CAP = fipwf_pkg::CAPACITY;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

    state_t                 state_reg;
    logic                   m_valid_reg;
    fipwf_pkg::out_t        m_data_reg;
    fipwf_pkg::cnt_t        count_reg, count_next;
    fipwf_pkg::cnt_t        fresh_reg, fresh_next;
    fipwf_pkg::cmd_t        cmd_reg;
    fipwf_pkg::word_t       idx_reg;
    fipwf_pkg::word_t       key_reg;
    logic                   last_ge_reg;
    logic                   last_le_reg;
    fipwf_pkg::entry_t      last_reg;

    fipwf_pkg::entry_t      cell_entry [CAP];
    logic                   cell_aoa   [CAP];
    logic [CAP:0]           occ;
    fipwf_pkg::entry_t      last_entry;
    fipwf_pkg::word_t       key_in;
    fipwf_pkg::cell_ctrl_t  ctrl;
    fipwf_pkg::out_t        out_next;
    fipwf_pkg::cell_op_t    op_next;
    logic                   accept;
    logic                   apply_go;
    logic                   front;
    logic                   lone;
    logic                   full;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign apply_go = (state_reg == S_APPLY) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // occupancy thermometer from the entry count
    genvar g;
    generate
        for (g = 0; g < CAP; g++) begin : g_occ
            assign occ[g] = (count_reg > fipwf_pkg::cnt_t'(g));
        end
    endgenerate
    assign occ[CAP] = 1'b0;

    // largest entry: the last occupied cell
    always_comb begin
        last_entry = '0;
        for (int k = 0; k < CAP; k++) begin
            if (occ[k] && !occ[k+1]) begin
                last_entry = last_entry | cell_entry[k];
            end
        end
    end

    always_comb begin
        case (s_data.cmd)
            fipwf_pkg::CMD_FRESH:   key_in = '0;
            fipwf_pkg::CMD_REQUEST: key_in = s_data.req_size;
            default:                key_in = s_data.block_size;
        endcase
    end

    assign full  = (count_reg == fipwf_pkg::cnt_t'(CAP));
    assign lone  = (count_reg == fipwf_pkg::cnt_t'(1)) && (fresh_reg == '0);
    assign front = (count_reg == '0) || (key_reg == '0) || (key_reg < cell_entry[0].size);

    always_comb begin
        op_next                 = fipwf_pkg::OP_HOLD;
        count_next              = count_reg;
        fresh_next              = fresh_reg;
        out_next.status         = fipwf_pkg::STAT_NONE;
        out_next.granted_index  = '0;
        out_next.granted_size   = '0;
        case (cmd_reg)
            fipwf_pkg::CMD_FRESH, fipwf_pkg::CMD_RELEASED: begin
                if (full) begin
                    out_next.status = fipwf_pkg::STAT_FULL;
                end else begin
                    out_next.status = fipwf_pkg::STAT_INSERTED;
                    op_next         = fipwf_pkg::OP_INSERT;
                    count_next      = count_reg + fipwf_pkg::cnt_t'(1);
                    if (cmd_reg == fipwf_pkg::CMD_FRESH) begin
                        fresh_next = fresh_reg + fipwf_pkg::cnt_t'(1);
                    end
                end
            end
            fipwf_pkg::CMD_REQUEST: begin
                if (count_reg != '0) begin
                    if (last_ge_reg) begin
                        out_next.status        = fipwf_pkg::STAT_GRANTED;
                        out_next.granted_index = last_reg.idx;
                        out_next.granted_size  = last_reg.size;
                    end else if (!lone && cell_entry[0].size == '0) begin
                        out_next.status        = fipwf_pkg::STAT_GRANTED;
                        out_next.granted_index = cell_entry[0].idx;
                        out_next.granted_size  = cell_entry[0].size;
                        op_next                = fipwf_pkg::OP_POP_FRONT;
                    end
                    if (out_next.status == fipwf_pkg::STAT_GRANTED) begin
                        count_next = count_reg - fipwf_pkg::cnt_t'(1);
                        if (out_next.granted_size == '0 && fresh_reg != '0) begin
                            fresh_next = fresh_reg - fipwf_pkg::cnt_t'(1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        out_next.entries_held = count_next;
        out_next.fresh_held   = fresh_next;
    end

    assign ctrl.capture        = accept;
    assign ctrl.key            = key_in;
    assign ctrl.op             = apply_go ? op_next : fipwf_pkg::OP_HOLD;
    assign ctrl.front          = front;
    assign ctrl.back           = last_le_reg;
    assign ctrl.new_entry.idx  = idx_reg;
    assign ctrl.new_entry.size = key_reg;

    generate
        for (g = 0; g < CAP; g++) begin : g_cell
            if (g == 0) begin : g_head
                fipwf_cell u_cell (
                    .aclk        (aclk),
                    .is_head     (1'b1),
                    .ctrl        (ctrl),
                    .occ         (occ[g]),
                    .left_aoa    (1'b0),
                    .left_entry  (ctrl.new_entry),
                    .right_entry (cell_entry[g+1]),
                    .entry       (cell_entry[g]),
                    .aoa         (cell_aoa[g])
                );
            end else if (g == CAP - 1) begin : g_tail
                fipwf_cell u_cell (
                    .aclk        (aclk),
                    .is_head     (1'b0),
                    .ctrl        (ctrl),
                    .occ         (occ[g]),
                    .left_aoa    (cell_aoa[g-1]),
                    .left_entry  (cell_entry[g-1]),
                    .right_entry (cell_entry[g]),
                    .entry       (cell_entry[g]),
                    .aoa         (cell_aoa[g])
                );
            end else begin : g_mid
                fipwf_cell u_cell (
                    .aclk        (aclk),
                    .is_head     (1'b0),
                    .ctrl        (ctrl),
                    .occ         (occ[g]),
                    .left_aoa    (cell_aoa[g-1]),
                    .left_entry  (cell_entry[g-1]),
                    .right_entry (cell_entry[g+1]),
                    .entry       (cell_entry[g]),
                    .aoa         (cell_aoa[g])
                );
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            fresh_reg   <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                    if (accept) begin
                        cmd_reg     <= s_data.cmd;
                        idx_reg     <= s_data.index_order;
                        key_reg     <= key_in;
                        last_reg    <= last_entry;
                        last_ge_reg <= (last_entry.size >= key_in);
                        last_le_reg <= (key_in >= last_entry.size);
                        state_reg   <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (apply_go) begin
                        m_data_reg  <= out_next;
                        m_valid_reg <= 1'b1;
                        count_reg   <= count_next;
                        fresh_reg   <= fresh_next;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/fipwf_cell.sv @@
// one cell of the sorted free list row
module fipwf_cell (
    input  logic                   aclk,
    input  logic                   is_head,
    input  fipwf_pkg::cell_ctrl_t  ctrl,
    input  logic                   occ,
    input  logic                   left_aoa,
    input  fipwf_pkg::entry_t      left_entry,
    input  fipwf_pkg::entry_t      right_entry,
    output fipwf_pkg::entry_t      entry,
    output logic                   aoa
);

    fipwf_pkg::entry_t entry_reg;
    logic              ge_reg;

    // at or after the insert position
    assign aoa   = ctrl.front || !occ || (!ctrl.back && !is_head && ge_reg);
    assign entry = entry_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            ge_reg <= (entry_reg.size >= ctrl.key);
        end
        case (ctrl.op)
            fipwf_pkg::OP_INSERT: begin
                if (aoa && !left_aoa) begin
                    entry_reg <= ctrl.new_entry;
                end else if (aoa) begin
                    entry_reg <= left_entry;
                end
            end
            fipwf_pkg::OP_POP_FRONT: begin
                entry_reg <= right_entry;
            end
            default: begin
            end
        endcase
    end

endmodule
